### sv/ljpf_pkg.sv
// Shared types, constants and arithmetic helpers for the Lennard-Jones pair force pipeline.
// No dependencies; the pipeline module refers to it by scoped names.
package ljpf_pkg;

  localparam int NUM_TYPES  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_R_FLOOR       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_TABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_TABLE = 2'd2;

  localparam logic [31:0] R_FLOOR_RST       = 32'd52429;
  localparam logic [63:0] SIGMA_TABLE_RST   = 64'h0100_0100_0100_0100;
  localparam logic [63:0] EPSILON_TABLE_RST = 64'h0500_0500_0500_0500;

  localparam logic [61:0] POW_CAP = 62'd1 << 61;

  typedef struct packed {
    logic             kill;
    logic [2:0]       dneg;
    logic [2:0][30:0] mag;
    logic [15:0]      sig;
    logic [20:0]      eps24;
  } meta_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    p.lh = 64'(a[31:0]) * 64'(b[63:32]);
    p.hl = 64'(a[63:32]) * 64'(b[31:0]);
    p.hh = 64'(a[63:32]) * 64'(b[63:32]);
    return p;
  endfunction

  function automatic logic [127:0] pp_full(input pp_t p);
    return {p.hh, p.ll} + (128'(p.lh) << 32) + (128'(p.hl) << 32);
  endfunction

  // floor(a*b / 2^32), saturated at 2^61
  function automatic logic [61:0] pow_fold(input pp_t p);
    logic [127:0] full;
    logic [95:0]  q;
    full = pp_full(p);
    q    = full[127:32];
    return (q > 96'(POW_CAP)) ? POW_CAP : 62'(q);
  endfunction

endpackage

### sv/ljpf_if.sv
// Request and result channel interfaces of the pair force pipeline.
// Depends on nothing; valid/ready handshake with the payload fields alongside.
interface ljpf_pair_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_i_x;
  logic signed [31:0] pos_i_y;
  logic signed [31:0] pos_i_z;
  logic signed [31:0] pos_j_x;
  logic signed [31:0] pos_j_y;
  logic signed [31:0] pos_j_z;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;
  logic signed [31:0] shift_z;
  logic               kind_i;
  logic               kind_j;

  modport source (output valid, pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z,
                  shift_x, shift_y, shift_z, kind_i, kind_j, input ready);
  modport sink (input valid, pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z,
                shift_x, shift_y, shift_z, kind_i, kind_j, output ready);
endinterface

interface ljpf_force_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] force_x;
  logic signed [47:0] force_y;
  logic signed [47:0] force_z;
  logic               clipped;

  modport source (output valid, force_x, force_y, force_z, clipped, input ready);
  modport sink (input valid, force_x, force_y, force_z, clipped, output ready);
endinterface

### sv/lennard_jones_pair_force.sv
// Lennard-Jones 12-6 pair force pipeline: one particle pair in, one force vector out per cycle.
// Uses ljpf_pkg for types and helpers, and ljpf_if.sv for the two channel interfaces.
//
// Accepts one request per clock and returns its force in order. The latency
// is set by the bit-per-stage units: a 32-stage square root of |d|^2, a 56-stage divider for
// sigma/r, four two-stage 64-bit multiplies for the powers of sigma/r, and three parallel
// 55-stage dividers by r^2 for the force components. The whole pipeline advances together;
// when the result register is full and not taken, every stage holds. Configuration writes
// take effect at once and are meant for an empty pipeline.
module lennard_jones_pair_force #(
  parameter int NUM_TYPES = ljpf_pkg::NUM_TYPES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ljpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ljpf_pkg::CFG_DATA_W-1:0]  cfg_data,
  ljpf_pair_if.sink                        pair_in,
  ljpf_force_if.source                     force_out
);

  typedef struct packed {
    ljpf_pkg::meta_t m;
    logic [63:0]     r2;
    logic [61:0]     u;
    logic [61:0]     a;
    logic [61:0]     u6;
    ljpf_pkg::pp_t   pp;
  } mst_t;

  typedef struct packed {
    ljpf_pkg::meta_t  m;
    logic             tneg;
    logic [63:0]      r2;
    logic [2:0]       sat;
    logic [2:0][63:0] rem;
    logic [2:0][62:0] num;
    logic [2:0][54:0] q;
  } fdst_t;

  logic [31:0] r_floor;
  logic [63:0] sigma_table;
  logic [63:0] epsilon_table;

  logic adv;
  assign adv = !force_out.valid || force_out.ready;
  assign pair_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_floor       <= ljpf_pkg::R_FLOOR_RST;
      sigma_table   <= ljpf_pkg::SIGMA_TABLE_RST;
      epsilon_table <= ljpf_pkg::EPSILON_TABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ljpf_pkg::CFG_R_FLOOR:       r_floor       <= cfg_data[31:0];
        ljpf_pkg::CFG_SIGMA_TABLE:   sigma_table   <= cfg_data;
        ljpf_pkg::CFG_EPSILON_TABLE: epsilon_table <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: difference vector, magnitudes, table lookup
  logic signed [33:0] d_in [3];
  logic [32:0]        mag_in [3];
  logic [1:0]         kidx;
  logic [15:0]        eps_in;
  ljpf_pkg::meta_t    m_in;

  always_comb begin
    d_in[0] = 34'(pair_in.pos_i_x) - 34'(pair_in.pos_j_x) + 34'(pair_in.shift_x);
    d_in[1] = 34'(pair_in.pos_i_y) - 34'(pair_in.pos_j_y) + 34'(pair_in.shift_y);
    d_in[2] = 34'(pair_in.pos_i_z) - 34'(pair_in.pos_j_z) + 34'(pair_in.shift_z);
    kidx    = 2'(32'(pair_in.kind_i) * NUM_TYPES + 32'(pair_in.kind_j));
    eps_in  = epsilon_table[16*kidx +: 16];
    m_in.kill  = 1'b0;
    m_in.sig   = sigma_table[16*kidx +: 16];
    m_in.eps24 = 21'({eps_in, 4'b0}) + 21'({eps_in, 3'b0});
    for (int c = 0; c < 3; c++) begin
      mag_in[c]    = d_in[c][33] ? 33'(-d_in[c]) : 33'(d_in[c]);
      m_in.dneg[c] = d_in[c][33];
      m_in.mag[c]  = mag_in[c][30:0];
      if (mag_in[c][32:31] != 2'b00) m_in.kill = 1'b1;
    end
  end

  logic            v0;
  ljpf_pkg::meta_t m0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= pair_in.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) m0 <= m_in;
  end

  // Squares, then their sum
  logic            v1, v2;
  ljpf_pkg::meta_t m1, m2;
  logic [61:0]     sq1 [3];
  logic [63:0]     s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1 <= m0;
      for (int c = 0; c < 3; c++) sq1[c] <= 62'(m0.mag[c]) * 62'(m0.mag[c]);
      m2 <= m1;
      s2 <= 64'(sq1[0]) + 64'(sq1[1]) + 64'(sq1[2]);
    end
  end

  // Square root, one result bit per stage
  logic            sq_v    [32];
  ljpf_pkg::meta_t sq_m    [32];
  logic [33:0]     sq_rem  [32];
  logic [31:0]     sq_root [32];
  logic [63:0]     sq_rad  [32];

  for (genvar i = 0; i < 32; i++) begin : g_sqrt
    logic            pv;
    ljpf_pkg::meta_t pm;
    logic [33:0]     prem;
    logic [31:0]     proot;
    logic [63:0]     prad;
    logic [35:0]     rem2;
    logic [35:0]     trial;

    if (i == 0) begin : g_head
      assign pv    = v2;
      assign pm    = m2;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = s2;
    end else begin : g_body
      assign pv    = sq_v[i-1];
      assign pm    = sq_m[i-1];
      assign prem  = sq_rem[i-1];
      assign proot = sq_root[i-1];
      assign prad  = sq_rad[i-1];
    end

    assign rem2  = {prem, prad[63:62]};
    assign trial = {2'b00, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) sq_v[i] <= 1'b0;
      else if (adv) sq_v[i] <= pv;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_m[i]   <= pm;
        sq_rad[i] <= {prad[61:0], 2'b00};
        if (rem2 >= trial) begin
          sq_rem[i]  <= 34'(rem2 - trial);
          sq_root[i] <= {proot[30:0], 1'b1};
        end else begin
          sq_rem[i]  <= 34'(rem2);
          sq_root[i] <= {proot[30:0], 1'b0};
        end
      end
    end
  end

  // Clamp r from below
  logic            rc_v;
  ljpf_pkg::meta_t rc_m;
  ljpf_pkg::meta_t rc_m_next;
  logic [31:0]     rc_r;
  logic [31:0]     r_cl;

  assign r_cl = (sq_root[31] >= r_floor) ? sq_root[31] : r_floor;

  always_comb begin
    rc_m_next      = sq_m[31];
    rc_m_next.kill = sq_m[31].kill || (r_cl == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) rc_v <= 1'b0;
    else if (adv) rc_v <= sq_v[31];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rc_m <= rc_m_next;
      rc_r <= r_cl;
    end
  end

  // u = sigma * 2^40 / r, one quotient bit per stage
  logic            dv_v   [56];
  ljpf_pkg::meta_t dv_m   [56];
  logic [31:0]     dv_rem [56];
  logic [55:0]     dv_q   [56];
  logic [55:0]     dv_num [56];
  logic [31:0]     dv_r   [56];
  logic [63:0]     dv_r2  [56];

  for (genvar i = 0; i < 56; i++) begin : g_udiv
    logic            pv;
    ljpf_pkg::meta_t pm;
    logic [31:0]     prem;
    logic [55:0]     pq;
    logic [55:0]     pnum;
    logic [31:0]     pr;
    logic [63:0]     pr2;
    logic [32:0]     rem2;
    logic            ge;

    if (i == 0) begin : g_head
      assign pv   = rc_v;
      assign pm   = rc_m;
      assign prem = '0;
      assign pq   = '0;
      assign pnum = {rc_m.sig, 40'd0};
      assign pr   = rc_r;
      assign pr2  = 64'(rc_r) * 64'(rc_r);
    end else begin : g_body
      assign pv   = dv_v[i-1];
      assign pm   = dv_m[i-1];
      assign prem = dv_rem[i-1];
      assign pq   = dv_q[i-1];
      assign pnum = dv_num[i-1];
      assign pr   = dv_r[i-1];
      assign pr2  = dv_r2[i-1];
    end

    assign rem2 = {prem, pnum[55]};
    assign ge   = rem2 >= {1'b0, pr};

    always_ff @(posedge clk) begin
      if (rst) dv_v[i] <= 1'b0;
      else if (adv) dv_v[i] <= pv;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_m[i]   <= pm;
        dv_r[i]   <= pr;
        dv_r2[i]  <= pr2;
        dv_num[i] <= {pnum[54:0], 1'b0};
        dv_q[i]   <= {pq[54:0], ge};
        dv_rem[i] <= ge ? 32'(rem2 - {1'b0, pr}) : 32'(rem2);
      end
    end
  end

  // Powers of u: u2, u3, u6, u12, each a partial-product stage and a fold stage
  logic ms_v [8];
  mst_t ms   [8];

  for (genvar j = 0; j < 8; j++) begin : g_pow
    logic pv;
    mst_t pst;
    mst_t nx;

    if (j == 0) begin : g_head
      assign pv = dv_v[55];
      always_comb begin
        pst    = '0;
        pst.m  = dv_m[55];
        pst.r2 = dv_r2[55];
        pst.u  = 62'(dv_q[55]);
        pst.a  = 62'(dv_q[55]);
      end
    end else begin : g_body
      assign pv  = ms_v[j-1];
      assign pst = ms[j-1];
    end

    always_comb begin
      nx = pst;
      if (j % 2 == 0) begin
        nx.pp = ljpf_pkg::pp_mul(64'(pst.a), 64'((j <= 2) ? pst.u : pst.a));
      end else begin
        nx.a = ljpf_pkg::pow_fold(pst.pp);
        if (j == 5) nx.u6 = nx.a;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) ms_v[j] <= 1'b0;
      else if (adv) ms_v[j] <= pv;
    end

    always_ff @(posedge clk) begin
      if (adv) ms[j] <= nx;
    end
  end

  // T = 2*u12 - u6 and the per-axis factor 24*eps*|d|
  logic             tt_v;
  ljpf_pkg::meta_t  tt_m;
  logic [63:0]      tt_r2;
  logic [62:0]      tt_tmag;
  logic             tt_tneg;
  logic [51:0]      tt_k [3];
  logic [62:0]      two_u12;
  logic [62:0]      u6_ext;

  assign two_u12 = {ms[7].a, 1'b0};
  assign u6_ext  = 63'(ms[7].u6);

  always_ff @(posedge clk) begin
    if (rst) tt_v <= 1'b0;
    else if (adv) tt_v <= ms_v[7];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tt_m  <= ms[7].m;
      tt_r2 <= ms[7].r2;
      if (two_u12 >= u6_ext) begin
        tt_tmag <= two_u12 - u6_ext;
        tt_tneg <= 1'b0;
      end else begin
        tt_tmag <= u6_ext - two_u12;
        tt_tneg <= 1'b1;
      end
      for (int c = 0; c < 3; c++) tt_k[c] <= 52'(ms[7].m.eps24) * 52'(ms[7].m.mag[c]);
    end
  end

  // Numerator |T| * 24*eps*|d|: partial products, then their sum
  logic            pk_v, nn_v;
  ljpf_pkg::meta_t pk_m, nn_m;
  logic [63:0]     pk_r2, nn_r2;
  logic            pk_tneg, nn_tneg;
  ljpf_pkg::pp_t   pk_pp [3];
  logic [114:0]    nn_n  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pk_v <= 1'b0;
      nn_v <= 1'b0;
    end else if (adv) begin
      pk_v <= tt_v;
      nn_v <= pk_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pk_m    <= tt_m;
      pk_r2   <= tt_r2;
      pk_tneg <= tt_tneg;
      nn_m    <= pk_m;
      nn_r2   <= pk_r2;
      nn_tneg <= pk_tneg;
      for (int c = 0; c < 3; c++) begin
        pk_pp[c] <= ljpf_pkg::pp_mul(64'(tt_tmag), 64'(tt_k[c]));
        nn_n[c]  <= 115'(ljpf_pkg::pp_full(pk_pp[c]));
      end
    end
  end

  // Saturation check ahead of the force dividers
  logic  fc_v;
  fdst_t fc;

  always_ff @(posedge clk) begin
    if (rst) fc_v <= 1'b0;
    else if (adv) fc_v <= nn_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fc.m    <= nn_m;
      fc.tneg <= nn_tneg;
      fc.r2   <= nn_r2;
      for (int c = 0; c < 3; c++) begin
        fc.sat[c] <= 64'(nn_n[c][114:63]) >= nn_r2;
        fc.rem[c] <= 64'(nn_n[c][114:63]);
        fc.num[c] <= nn_n[c][62:0];
        fc.q[c]   <= '0;
      end
    end
  end

  // Force magnitude / r^2 / 256, one quotient bit per stage on all three axes
  logic  fd_v [55];
  fdst_t fd   [55];

  for (genvar j = 0; j < 55; j++) begin : g_fdiv
    logic        pv;
    fdst_t       pst;
    fdst_t       nx;
    logic [64:0] rem2 [3];
    logic        ge   [3];

    if (j == 0) begin : g_head
      assign pv  = fc_v;
      assign pst = fc;
    end else begin : g_body
      assign pv  = fd_v[j-1];
      assign pst = fd[j-1];
    end

    always_comb begin
      nx = pst;
      for (int c = 0; c < 3; c++) begin
        rem2[c]   = {pst.rem[c], pst.num[c][62]};
        ge[c]     = rem2[c] >= {1'b0, pst.r2};
        nx.rem[c] = ge[c] ? 64'(rem2[c] - {1'b0, pst.r2}) : 64'(rem2[c]);
        nx.num[c] = {pst.num[c][61:0], 1'b0};
        nx.q[c]   = {pst.q[c][53:0], ge[c]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) fd_v[j] <= 1'b0;
      else if (adv) fd_v[j] <= pv;
    end

    always_ff @(posedge clk) begin
      if (adv) fd[j] <= nx;
    end
  end

  // Sign, output saturation, result register
  logic [55:0] fmag [3];
  logic [55:0] flim [3];
  logic        fneg [3];
  logic [47:0] fval [3];
  logic        clip_next;

  always_comb begin
    clip_next = 1'b0;
    for (int c = 0; c < 3; c++) begin
      fmag[c] = fd[54].sat[c] ? (56'd1 << 55) : {1'b0, fd[54].q[c]};
      fneg[c] = (fd[54].tneg != fd[54].m.dneg[c]) && (fmag[c] != 56'd0);
      flim[c] = fneg[c] ? (56'd1 << 47) : ((56'd1 << 47) - 56'd1);
      if (fmag[c] > flim[c]) begin
        fmag[c]   = flim[c];
        clip_next = 1'b1;
      end
      fval[c] = fneg[c] ? 48'(-fmag[c]) : 48'(fmag[c]);
      if (fd[54].m.kill) fval[c] = '0;
    end
    if (fd[54].m.kill) clip_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) force_out.valid <= 1'b0;
    else if (adv) force_out.valid <= fd_v[54];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      force_out.force_x <= fval[0];
      force_out.force_y <= fval[1];
      force_out.force_z <= fval[2];
      force_out.clipped <= clip_next;
    end
  end

endmodule
